// File: sv/gls_pkg.sv
// Shared types and constants for the grid Laplacian smoother.
// No dependencies; imported by gls_line_buf and grid_laplacian_smoother_unit.
`default_nettype none

package gls_pkg;

  localparam int NUM_AXES   = 3;   // x, y, z lanes
  localparam int WEIGHT_W   = 16;  // unsigned Q0.16 gain
  localparam int DIM_W      = 7;   // grid_rows / grid_cols register width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_IDX_W  = 6;   // out_row / out_col width
  localparam int FRAC_BITS  = 16;

  // one half of an output LSB, placed below the shifted center
  localparam logic [FRAC_BITS-1:0] ROUND_HALF = 16'h8000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd2;

  // per-point bookkeeping carried down the pipeline
  typedef struct packed {
    logic                 has_a;   // point one row above is emitted
    logic                 has_b;   // the new point itself is emitted (last row)
    logic                 smooth;  // point above is interior and weight is nonzero
    logic                 last;    // new point is the last column of its row
    logic [OUT_IDX_W-1:0] row_a;
    logic [OUT_IDX_W-1:0] row_b;
    logic [OUT_IDX_W-1:0] col;
  } gls_meta_t;

endpackage

`default_nettype wire

// File: sv/gls_line_buf.sv
// Two-bank line store holding the two most recent grid rows (x, y, z packed).
// Uses gls_pkg; instantiated by grid_laplacian_smoother_unit.
`default_nettype none

module gls_line_buf import gls_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int MAX_COLS    = 64
) (
  input  wire logic                            clk,
  input  wire logic                            acc,
  input  wire logic                            parity,
  input  wire logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col,
  input  wire logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col_right,
  input  wire logic [NUM_AXES*COORD_WIDTH-1:0] wr_data,
  output logic      [NUM_AXES*COORD_WIDTH-1:0] center,
  output logic      [NUM_AXES*COORD_WIDTH-1:0] right,
  output logic      [NUM_AXES*COORD_WIDTH-1:0] up
);

  localparam int WORD_W = NUM_AXES * COORD_WIDTH;

  logic [WORD_W-1:0] bank0 [MAX_COLS];
  logic [WORD_W-1:0] bank1 [MAX_COLS];
  logic [WORD_W-1:0] b0_a, b0_b, b1_a, b1_b;
  logic              parity_q;

  // read-before-write: a read of the entry being written returns the old row
  always_ff @(posedge clk) begin
    if (acc) begin
      if (!parity) bank0[col] <= wr_data;
      b0_a <= bank0[col];
      b0_b <= bank0[col_right];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (parity) bank1[col] <= wr_data;
      b1_a <= bank1[col];
      b1_b <= bank1[col_right];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) parity_q <= parity;
  end

  // the bank of the other parity holds the row above the incoming one
  assign center = parity_q ? b0_a : b1_a;
  assign right  = parity_q ? b0_b : b1_b;
  assign up     = parity_q ? b1_a : b0_a;

endmodule

`default_nettype wire

// File: sv/grid_laplacian_smoother_unit.sv
// Top level of the 5-point Laplacian grid smoother.
// Uses gls_pkg and gls_line_buf.
`default_nettype none

// Streams a grid of 3-D points in row-major order, one point per input beat,
// and returns each point as p + w*(up+down+left+right-4p) using unsmoothed
// neighbors; border points, and every point when the weight is zero, pass
// unchanged. Results lag the input by one row: the beat for point (r,c)
// releases point (r-1,c), and on the last row it also releases (r,c) itself,
// so each last-row input beat yields two output points. Otherwise one point
// is taken per clock while out_ready holds. Each beat passes in order through
// line-store read, Laplacian, gain multiply, rounded add and saturate.
// The two previous rows live in a two-bank line store (MAX_COLS entries per
// bank, x/y/z packed); it is not cleared after reset and needs no clearing
// pass, since every entry is written before the stencil reads it. Writing
// grid_rows or grid_cols restarts the grid at row 0, column 0. Change the
// configuration only while the block is idle.

module grid_laplacian_smoother_unit import gls_pkg::*; #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write port
  input  wire logic                          cfg_write,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  // input points
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] point_x,
  input  wire logic signed [COORD_WIDTH-1:0] point_y,
  input  wire logic signed [COORD_WIDTH-1:0] point_z,
  // smoothed points
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_x,
  output logic signed [COORD_WIDTH-1:0]      out_y,
  output logic signed [COORD_WIDTH-1:0]      out_z,
  output logic [OUT_IDX_W-1:0]               out_row,
  output logic [OUT_IDX_W-1:0]               out_col,
  output logic                               last_point
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LW  = COORD_WIDTH + 3;          // Laplacian
  localparam int PW  = LW + WEIGHT_W + 1;        // gain product
  localparam int SW  = PW + 1;                   // product plus shifted center
  localparam int VW  = SW - FRAC_BITS;           // result before saturation

  // saturate a widened result to the coordinate range
  function automatic logic [COORD_WIDTH-1:0] sat(input logic [VW-1:0] v);
    logic [VW-COORD_WIDTH:0] hi;
    hi = v[VW-1:COORD_WIDTH-1];
    if (hi == '0 || hi == '1) return v[COORD_WIDTH-1:0];
    else if (v[VW-1])         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    else                      return {1'b0, {(COORD_WIDTH-1){1'b1}}};
  endfunction

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic [WEIGHT_W-1:0] weight;
  logic [DIM_W-1:0]    grid_rows;
  logic [DIM_W-1:0]    grid_cols;
  logic [RW-1:0]       rows_last;
  logic [CW-1:0]       cols_last;

  // effective size: zero counts as one, large values clamp to the maximum
  always_comb begin
    if (grid_rows == '0)                 rows_last = '0;
    else if (32'(grid_rows) > MAX_ROWS)  rows_last = RW'(MAX_ROWS - 1);
    else                                 rows_last = RW'(grid_rows - DIM_W'(1));
    if (grid_cols == '0)                 cols_last = '0;
    else if (32'(grid_cols) > MAX_COLS)  cols_last = CW'(MAX_COLS - 1);
    else                                 cols_last = CW'(grid_cols - DIM_W'(1));
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake: each stage advances when it is empty or its
  // successor takes its contents
  // ---------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4, r5;
  logic a_pend, b_pend;
  logic in_acc;

  assign r5 = !(a_pend || b_pend) || (out_ready && (a_pend ^ b_pend));
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;
  assign in_acc   = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Position counters and configuration registers
  // ---------------------------------------------------------------------
  logic [RW-1:0] in_row;
  logic [CW-1:0] in_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight    <= '0;
      grid_rows <= DIM_W'(1);
      grid_cols <= DIM_W'(1);
      in_row    <= '0;
      in_col    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WEIGHT: weight <= cfg_data[WEIGHT_W-1:0];
        CFG_ROWS: begin
          grid_rows <= cfg_data[DIM_W-1:0];
          in_row    <= '0;
          in_col    <= '0;
        end
        CFG_COLS: begin
          grid_cols <= cfg_data[DIM_W-1:0];
          in_row    <= '0;
          in_col    <= '0;
        end
        default: ;  // writes past the register list are dropped
      endcase
    end else if (in_acc) begin
      if (in_col == cols_last) begin
        in_col <= '0;
        in_row <= (in_row == rows_last) ? '0 : in_row + RW'(1);
      end else begin
        in_col <= in_col + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Accept: classify the beat and address the line store
  // ---------------------------------------------------------------------
  gls_meta_t     meta0;
  logic [RW-1:0] row_above;
  logic [CW-1:0] col_right;

  assign row_above = in_row - RW'(1);
  // hold the right address in range on the last column; it is not used there
  assign col_right = (in_col == cols_last) ? in_col : in_col + CW'(1);

  always_comb begin
    meta0.has_a  = (in_row != '0);
    meta0.has_b  = (in_row == rows_last);
    meta0.smooth = (in_row > RW'(1)) && (in_col != '0) && (in_col < cols_last)
                   && (weight != '0);
    meta0.last   = (in_col == cols_last);
    meta0.row_a  = OUT_IDX_W'(row_above);
    meta0.row_b  = OUT_IDX_W'(in_row);
    meta0.col    = OUT_IDX_W'(in_col);
  end

  logic [NUM_AXES*COORD_WIDTH-1:0] lb_center, lb_right, lb_up;

  gls_line_buf #(
    .COORD_WIDTH (COORD_WIDTH),
    .MAX_COLS    (MAX_COLS)
  ) u_line_buf (
    .clk       (clk),
    .acc       (in_acc),
    .parity    (in_row[0]),
    .col       (in_col),
    .col_right (col_right),
    .wr_data   ({point_z, point_y, point_x}),
    .center    (lb_center),
    .right     (lb_right),
    .up        (lb_up)
  );

  // ---------------------------------------------------------------------
  // Stage valids and bookkeeping
  // ---------------------------------------------------------------------
  gls_meta_t meta1, meta2, meta3, meta4, meta5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      v4     <= 1'b0;
      a_pend <= 1'b0;
      b_pend <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) begin
        // load both results of the next point; points that release nothing vanish
        a_pend <= v4 && meta4.has_a;
        b_pend <= v4 && meta4.has_b;
      end else if (out_ready && a_pend) begin
        a_pend <= 1'b0;  // point above goes first, the last-row point follows
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) meta1 <= meta0;
    if (r2)     meta2 <= meta1;
    if (r3)     meta3 <= meta2;
    if (r4)     meta4 <= meta3;
    if (r5)     meta5 <= meta4;
  end

  // ---------------------------------------------------------------------
  // Per-axis datapath
  // ---------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] in_pt [NUM_AXES];
  logic        [COORD_WIDTH-1:0] a_dat [NUM_AXES];
  logic        [COORD_WIDTH-1:0] b_dat [NUM_AXES];

  assign in_pt[0] = point_x;
  assign in_pt[1] = point_y;
  assign in_pt[2] = point_z;

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
    logic signed [COORD_WIDTH-1:0] cen, rgt, upv;
    logic signed [COORD_WIDTH-1:0] s1_pin, s1_left;
    logic signed [COORD_WIDTH-1:0] s2_cen, s2_pin, s3_cen, s3_pin, s4_pin;
    logic signed [LW-1:0]          s2_lap;
    logic signed [PW-1:0]          s3_prod;
    logic signed [SW-1:0]          sum;
    logic        [VW-1:0]          s4_val;

    assign cen = lb_center[k*COORD_WIDTH +: COORD_WIDTH];
    assign rgt = lb_right [k*COORD_WIDTH +: COORD_WIDTH];
    assign upv = lb_up    [k*COORD_WIDTH +: COORD_WIDTH];

    // rounding half sits below the center's integer alignment, so one add
    // forms center + w*lap + 0.5
    assign sum = SW'(s3_prod) + SW'($signed({s3_cen, ROUND_HALF}));

    always_ff @(posedge clk) begin
      // stage 1: the left neighbor is the previous beat's center
      if (in_acc) begin
        s1_pin  <= in_pt[k];
        s1_left <= cen;
      end
      // stage 2: Laplacian
      if (r2) begin
        s2_lap <= LW'(upv) + LW'(s1_pin) + LW'(s1_left) + LW'(rgt) - (LW'(cen) <<< 2);
        s2_cen <= cen;
        s2_pin <= s1_pin;
      end
      // stage 3: gain multiply
      if (r3) begin
        s3_prod <= $signed({1'b0, weight}) * s2_lap;
        s3_cen  <= s2_cen;
        s3_pin  <= s2_pin;
      end
      // stage 4: rounded add, or pass the center through
      if (r4) begin
        s4_val <= meta3.smooth ? sum[SW-1:FRAC_BITS] : VW'(s3_cen);
        s4_pin <= s3_pin;
      end
      // stage 5: saturate into the output register
      if (r5) begin
        a_dat[k] <= sat(s4_val);
        b_dat[k] <= s4_pin;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output select: point above first, then the last-row point
  // ---------------------------------------------------------------------
  assign out_valid  = a_pend || b_pend;
  assign out_x      = a_pend ? a_dat[0] : b_dat[0];
  assign out_y      = a_pend ? a_dat[1] : b_dat[1];
  assign out_z      = a_pend ? a_dat[2] : b_dat[2];
  assign out_row    = a_pend ? meta5.row_a : meta5.row_b;
  assign out_col    = meta5.col;
  assign last_point = !a_pend && meta5.last;

endmodule

`default_nettype wire
